[hw/rtl/pge_pkg.sv]
// Package for the pheromone grid explorer: types, codes and sizes.
// No dependencies.
package pge_pkg;
  localparam int GridRows = 64;
  localparam int GridCols = 64;
  localparam int RowW = 6;
  localparam int ColW = 6;
  localparam int AddrW = RowW + ColW;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0, OP_PLACE = 2'd1, OP_MOVE = 2'd2, OP_EVAP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_WALL = 2'd1, ST_NOFREE = 2'd2, ST_RANGE = 2'd3
  } status_t;

  localparam logic [1:0] CellWall    = 2'd1;
  localparam logic [1:0] CellRobot   = 2'd2;
  localparam logic [1:0] CellVisited = 2'd3;

  typedef enum logic [2:0] {
    CFG_ROWS = 3'd0, CFG_COLS = 3'd1, CFG_NGAIN = 3'd2, CFG_CGAIN = 3'd3,
    CFG_EVAP = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SIMPLE, S_NRD, S_NWAIT, S_NMUL, S_NWR, S_CMUL, S_CWR,
    S_RMUL, S_RCMP, S_ESTEP, S_EWAIT, S_EMUL, S_EWR, S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } result_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [1:0]  cell_code;
    logic [15:0] random_value;
  } request_t;
endpackage

[hw/rtl/pge_if.sv]
// Valid/ready channel carrying one payload.
// Depends on nothing; payload type is a parameter.
interface pge_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/pheromone_grid_explorer_unit.sv]
// Top level of the pheromone grid explorer: sequencer, grid memories, config.
// Depends on pge_pkg, pge_if and pge_mac.
//
//  channel | dir | fields
//  in_     | in  | operation, row, col, cell_code, random_value
//  out_    | out | status, robot_row, robot_col
//  cfg_    | in  | cfg_we, cfg_index, cfg_wdata (16b)
//
// Load and place check the target's range, then finish. A move scans the
// neighbours and deposits on each free one, skips the center slot, deposits
// on the center, walks the roulette candidates and finishes. Evaporate
// steps through every used cell with the one memory port and the shared
// multiplier. rst_n is synchronous; the grid memories are not cleared. The
// result is held in an output register until taken; no request is
// accepted while one is in work or waiting.
module pheromone_grid_explorer_unit import pge_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pge_if.sink         in_ch,
  pge_if.source       out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  logic [6:0]  rows_r, cols_r;
  logic [15:0] ngain_r, cgain_r, evap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 7'd64; cols_r <= 7'd64;
      ngain_r <= 16'd14299; cgain_r <= 16'd42598; evap_r <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROWS:  rows_r  <= cfg_wdata[6:0];
        CFG_COLS:  cols_r  <= cfg_wdata[6:0];
        CFG_NGAIN: ngain_r <= cfg_wdata;
        CFG_CGAIN: cgain_r <= cfg_wdata;
        CFG_EVAP:  evap_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective grid size, clamped to the storage
  logic [6:0] erows, ecols;
  assign erows = (rows_r > 7'(GridRows)) ? 7'(GridRows) : rows_r;
  assign ecols = (cols_r > 7'(GridCols)) ? 7'(GridCols) : cols_r;

  // grid memories, one port each, registered read
  logic [1:0]  cell_mem [GridRows*GridCols];
  logic [15:0] pher_mem [GridRows*GridCols];
  logic [AddrW-1:0] addr;
  logic        cell_we, pher_we;
  logic [1:0]  cell_wd;
  logic [15:0] pher_wd;
  logic [1:0]  cell_rd_r;
  logic [15:0] pher_rd_r;

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[addr] <= cell_wd;
    cell_rd_r <= cell_mem[addr];
  end
  always_ff @(posedge clk) begin
    if (pher_we) pher_mem[addr] <= pher_wd;
    pher_rd_r <= pher_mem[addr];
  end

  state_t state_r, state_nxt;
  request_t req_r;
  result_t  res_r;
  logic     out_valid_r;
  logic [RowW-1:0] rrow_r, rrow_nxt;
  logic [ColW-1:0] rcol_r, rcol_nxt;
  logic [1:0] status_r, status_nxt;
  logic [3:0] nb_r, nb_nxt;          // neighbour scan index 0..8
  logic [3:0] ncand_r, ncand_nxt;
  logic [16:0] wt_r [8];
  logic [AddrW-1:0] cand_r [8];
  logic [19:0] sum_r, sum_nxt;
  logic [19:0] acc_r, acc_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [RowW-1:0] er_r, er_nxt;
  logic [ColW-1:0] ec_r, ec_nxt;
  logic        wt_we;
  logic [16:0] wt_wd;

  // shared multiplier
  logic [16:0] mul_a, mul_b;
  logic [33:0] prod_r;
  pge_mac u_mac (.clk(clk), .a(mul_a), .b(mul_b), .prod_r(prod_r));

  // row and column offset (plus one) of the scan index, raster order
  logic [1:0] nb_dr, nb_dc;
  always_comb begin
    case (nb_r)
      4'd0, 4'd1, 4'd2: nb_dr = 2'd0;
      4'd3, 4'd4, 4'd5: nb_dr = 2'd1;
      default:          nb_dr = 2'd2;
    endcase
    case (nb_r)
      4'd0, 4'd3, 4'd6: nb_dc = 2'd0;
      4'd1, 4'd4, 4'd7: nb_dc = 2'd1;
      default:          nb_dc = 2'd2;
    endcase
  end

  // neighbour coordinates for scan index
  logic signed [7:0] nr, nc;
  logic nb_in;
  always_comb begin
    nr = $signed({2'b00, rrow_r}) + $signed({6'd0, nb_dr}) - 8'sd1;
    nc = $signed({2'b00, rcol_r}) + $signed({6'd0, nb_dc}) - 8'sd1;
    nb_in = (nb_r != 4'd4) && (nr >= 0) && (nc >= 0) &&
            (nr < $signed({1'b0, erows})) && (nc < $signed({1'b0, ecols}));
  end

  logic [15:0] pdep;
  logic [16:0] pdsum;
  logic [35:0] rhs;
  always_comb begin
    pdsum = {1'b0, pher_rd_r} + {1'b0, prod_r[31:16]};
    pdep  = pdsum[16] ? 16'hFFFF : pdsum[15:0];
    rhs = {16'd0, sum_r} * 36'(req_r.random_value);
  end

  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = res_r;

  always_comb begin
    state_nxt = state_r;
    rrow_nxt = rrow_r; rcol_nxt = rcol_r; status_nxt = status_r;
    nb_nxt = nb_r; ncand_nxt = ncand_r; sum_nxt = sum_r; acc_nxt = acc_r;
    k_nxt = k_r; er_nxt = er_r; ec_nxt = ec_r;
    addr = {req_r.row, req_r.col};
    cell_we = 1'b0; pher_we = 1'b0; cell_wd = req_r.cell_code; pher_wd = '0;
    mul_a = {1'b0, pher_rd_r}; mul_b = {1'b0, evap_r};
    wt_we = 1'b0; wt_wd = 17'h10000 - {1'b0, pdep};
    case (state_r)
      S_IDLE: if (in_ch.valid && in_ch.ready) begin
        status_nxt = ST_OK;
        case (op_t'(in_ch.data.operation))
          OP_MOVE: begin
            nb_nxt = '0; ncand_nxt = '0; sum_nxt = '0;
            state_nxt = (rrow_r >= erows[RowW-1:0] && erows[6] == 1'b0) ||
                        ({1'b0, rrow_r} >= erows) || ({1'b0, rcol_r} >= ecols)
                        ? S_DONE : S_NRD;
            if (({1'b0, rrow_r} >= erows) || ({1'b0, rcol_r} >= ecols))
              status_nxt = ST_RANGE;
          end
          OP_EVAP: begin
            // an empty grid has nothing to scale
            er_nxt = '0; ec_nxt = '0;
            state_nxt = (erows == 7'd0 || ecols == 7'd0) ? S_DONE : S_ESTEP;
          end
          default: state_nxt = S_SIMPLE;
        endcase
      end
      S_SIMPLE: begin
        // memory read of target issued this cycle; the data is seen in S_NWAIT
        if (({1'b0, req_r.row} >= erows) || ({1'b0, req_r.col} >= ecols)) begin
          status_nxt = ST_RANGE; state_nxt = S_DONE;
        end else if (op_t'(req_r.operation) == OP_LOAD) begin
          cell_we = 1'b1; pher_we = 1'b1; state_nxt = S_DONE;
        end else begin
          state_nxt = S_NWAIT; // reuse wait to see read data
          nb_nxt = 4'hF;
        end
      end
      S_NRD: begin
        if (nb_r == 4'd9) begin
          addr = {rrow_r, rcol_r}; state_nxt = S_CMUL; nb_nxt = 4'hE;
        end else if (!nb_in) begin
          nb_nxt = nb_r + 4'd1;
        end else begin
          addr = {nr[RowW-1:0], nc[ColW-1:0]}; state_nxt = S_NWAIT;
        end
      end
      S_NWAIT: begin
        if (nb_r == 4'hF) begin
          // place: read data valid now
          if (cell_rd_r == CellWall) status_nxt = ST_WALL;
          else begin
            cell_we = 1'b1; cell_wd = CellRobot;
            rrow_nxt = req_r.row; rcol_nxt = req_r.col;
          end
          state_nxt = S_DONE;
        end else begin
          addr = {nr[RowW-1:0], nc[ColW-1:0]};
          mul_a = 17'h10000 - {1'b0, pher_rd_r}; mul_b = {1'b0, ngain_r};
          state_nxt = (cell_rd_r == CellWall) ? S_NRD : S_NMUL;
          if (cell_rd_r == CellWall) nb_nxt = nb_r + 4'd1;
        end
      end
      S_NMUL: begin
        addr = {nr[RowW-1:0], nc[ColW-1:0]};
        pher_we = 1'b1; pher_wd = pdep; wt_we = 1'b1;
        sum_nxt = sum_r + 20'(wt_wd);
        ncand_nxt = ncand_r + 4'd1; nb_nxt = nb_r + 4'd1;
        state_nxt = S_NRD;
      end
      S_CMUL: begin
        addr = {rrow_r, rcol_r};
        mul_a = 17'h10000 - {1'b0, pher_rd_r}; mul_b = {1'b0, cgain_r};
        state_nxt = S_CWR;
      end
      S_CWR: begin
        addr = {rrow_r, rcol_r}; pher_we = 1'b1; pher_wd = pdep;
        if (ncand_r == 4'd0) begin
          status_nxt = ST_NOFREE; state_nxt = S_DONE;
        end else begin
          k_nxt = '0; acc_nxt = '0; state_nxt = S_RMUL;
        end
      end
      S_RMUL: begin
        acc_nxt = acc_r + 20'(wt_r[k_r]);
        state_nxt = S_RCMP;
      end
      S_RCMP: begin
        if ((sum_r != 0) && ({acc_r, 16'd0} >= rhs) ||
            ({1'b0, k_r} == ncand_r - 4'd1)) begin
          addr = {rrow_r, rcol_r}; cell_we = 1'b1; cell_wd = CellVisited;
          state_nxt = S_NWR;
        end else begin
          k_nxt = k_r + 3'd1; state_nxt = S_RMUL;
        end
      end
      S_NWR: begin
        addr = cand_r[k_r]; cell_we = 1'b1; cell_wd = CellRobot;
        rrow_nxt = cand_r[k_r][AddrW-1:ColW]; rcol_nxt = cand_r[k_r][ColW-1:0];
        state_nxt = S_DONE;
      end
      S_ESTEP: begin
        addr = {er_r, ec_r}; state_nxt = S_EWAIT;
      end
      S_EWAIT: begin
        addr = {er_r, ec_r}; state_nxt = S_EMUL;
      end
      S_EMUL: begin
        addr = {er_r, ec_r}; state_nxt = S_EWR;
      end
      S_EWR: begin
        addr = {er_r, ec_r}; pher_we = 1'b1;
        pher_wd = pher_rd_r - prod_r[31:16];
        if ({1'b0, ec_r} == ecols - 7'd1) begin
          ec_nxt = '0;
          if ({1'b0, er_r} == erows - 7'd1) state_nxt = S_DONE;
          else begin er_nxt = er_r + 1'b1; state_nxt = S_ESTEP; end
        end else begin
          ec_nxt = ec_r + 1'b1; state_nxt = S_ESTEP;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // mul in S_EWAIT uses data read in S_ESTEP; default mux already set

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid_r <= 1'b0;
      rrow_r <= '0; rcol_r <= '0;
    end else begin
      state_r <= state_nxt; rrow_r <= rrow_nxt; rcol_r <= rcol_nxt;
      if (state_r == S_DONE) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) req_r <= in_ch.data;
    status_r <= status_nxt; nb_r <= nb_nxt; ncand_r <= ncand_nxt;
    sum_r <= sum_nxt; acc_r <= acc_nxt; k_r <= k_nxt;
    er_r <= er_nxt; ec_r <= ec_nxt;
    if (wt_we) begin
      wt_r[ncand_r[2:0]] <= wt_wd;
      cand_r[ncand_r[2:0]] <= addr;
    end
    if (state_r == S_DONE) res_r <= '{status: status_r, row: rrow_r, col: rcol_r};
  end

  // no request taken while a result waits
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ch.ready) else $error("request taken while busy");
  // at most eight candidates
  a_cand: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_NMUL |-> ncand_r < 4'd8) else $error("candidate overflow");
  // result shows up in the cycle after finishing
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> out_valid_r) else $error("result lost");
endmodule

[hw/rtl/pge_mac.sv]
// Shared 17x17 multiplier with registered product.
// Uses pge_pkg only for style consistency.
module pge_mac import pge_pkg::*; (
  input  logic        clk,
  input  logic [16:0] a,
  input  logic [16:0] b,
  output logic [33:0] prod_r
);
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end
endmodule

[tb/sv/pge_checker.sv]
`timescale 1ns / 1ps
// Result checker for the pheromone grid explorer: watches the request, result
// and register ports, predicts each result and compares it. Depends on pge_pkg.
module pge_checker import pge_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  request_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  result_t     out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  localparam int Cells = GridRows * GridCols;

  logic [1:0]  grid_code [Cells];
  logic [15:0] grid_level [Cells];
  logic [5:0]  bot_row, bot_col;
  logic [6:0]  rows_reg, cols_reg;
  logic [15:0] ngain, cgain, evap;
  result_t     due_q[$];
  int          errs;

  function automatic int used_rows();
    return (rows_reg > GridRows) ? GridRows : int'(rows_reg);
  endfunction

  function automatic int used_cols();
    return (cols_reg > GridCols) ? GridCols : int'(cols_reg);
  endfunction

  // Saturating Q0.16 deposit toward one.
  function automatic logic [15:0] deposit(logic [15:0] p, logic [15:0] gain);
    longint unsigned add, v;
    add = ((longint'(65536) - p) * gain) >> 16;
    v = p + add;
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [1:0] robot_step(logic [15:0] draw);
    int rows, cols, n, k, nr, nc, idx, ci;
    int cand [8];
    longint unsigned wt [8];
    longint unsigned sum, acc;
    rows = used_rows();
    cols = used_cols();
    n = 0;
    sum = 0;
    acc = 0;
    if (bot_row >= rows || bot_col >= cols) return ST_RANGE;
    for (int di = -1; di <= 1; di++) begin
      for (int dj = -1; dj <= 1; dj++) begin
        nr = int'(bot_row) + di;
        nc = int'(bot_col) + dj;
        if (di == 0 && dj == 0) continue;
        if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
        idx = nr * GridCols + nc;
        if (grid_code[idx] == CellWall) continue;
        grid_level[idx] = deposit(grid_level[idx], ngain);
        cand[n] = idx;
        wt[n] = 65536 - grid_level[idx];
        sum += wt[n];
        n++;
      end
    end
    ci = int'(bot_row) * GridCols + int'(bot_col);
    grid_level[ci] = deposit(grid_level[ci], cgain);
    if (n == 0) return ST_NOFREE;
    // roulette: first candidate whose running weight reaches the draw
    k = n - 1;
    if (sum != 0) begin
      for (int i = 0; i < n; i++) begin
        acc += wt[i];
        if (acc * 65536 >= longint'(draw) * sum) begin
          k = i;
          break;
        end
      end
    end
    grid_code[ci] = CellVisited;
    grid_code[cand[k]] = CellRobot;
    bot_row = 6'(cand[k] / GridCols);
    bot_col = 6'(cand[k] % GridCols);
    return ST_OK;
  endfunction

  function automatic result_t predict(request_t rq);
    result_t res;
    int idx;
    logic [15:0] p;
    res.status = ST_OK;
    case (op_t'(rq.operation))
      OP_LOAD, OP_PLACE: begin
        if (rq.row >= used_rows() || rq.col >= used_cols()) begin
          res.status = ST_RANGE;
        end else begin
          idx = int'(rq.row) * GridCols + int'(rq.col);
          if (rq.operation == OP_LOAD) begin
            grid_code[idx] = rq.cell_code;
            grid_level[idx] = '0;
          end else if (grid_code[idx] == CellWall) begin
            res.status = ST_WALL;
          end else begin
            bot_row = rq.row;
            bot_col = rq.col;
            grid_code[idx] = CellRobot;
          end
        end
      end
      OP_MOVE: res.status = robot_step(rq.random_value);
      default: begin
        for (int i = 0; i < used_rows(); i++) begin
          for (int j = 0; j < used_cols(); j++) begin
            p = grid_level[i * GridCols + j];
            grid_level[i * GridCols + j] = p - 16'((longint'(p) * evap) >> 16);
          end
        end
      end
    endcase
    res.row = bot_row;
    res.col = bot_col;
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errs++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      bot_row = '0;
      bot_col = '0;
      rows_reg = 7'd64;
      cols_reg = 7'd64;
      ngain = 16'd14299;
      cgain = 16'd42598;
      evap = '0;
      due_q.delete();
      errs = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ROWS:  rows_reg = cfg_wdata[6:0];
          CFG_COLS:  cols_reg = cfg_wdata[6:0];
          CFG_NGAIN: ngain = cfg_wdata;
          CFG_CGAIN: cgain = cfg_wdata;
          CFG_EVAP:  evap = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) due_q.push_back(predict(in_data));
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          report("unexpected result, status", out_data.status, -1);
        end else begin
          want = due_q.pop_front();
          if (out_data.status != want.status) report("status", out_data.status, want.status);
          if (out_data.row != want.row) report("robot_row", out_data.row, want.row);
          if (out_data.col != want.col) report("robot_col", out_data.col, want.col);
        end
      end
    end
    pending <= due_q.size();
    fail_count <= errs;
  end
endmodule

[tb/sv/tb_pheromone_grid_explorer_unit.sv]
`timescale 1ns / 1ps
// Top of the pheromone grid explorer testbench: clock, reset, request and
// register stimulus, result stalls and verdict. Depends on pge_pkg, pge_if,
// pge_checker and the block itself.
module tb_pheromone_grid_explorer_unit;
  import pge_pkg::*;

  localparam int FillSide = 12;   // corner block written before any use

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  int          fail_count, pending;
  bit          quiet;       // no gaps and no stalls while set
  int          stall_left;
  int          rows_now, cols_now;

  pge_if #(.payload_t(request_t)) in_ch (clk);
  pge_if #(.payload_t(result_t))  out_ch (clk);

  pheromone_grid_explorer_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  pge_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  // Gap length: half none, mostly short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side back-pressure, same length mix as the request gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) stall_left <= pick_gap();
    end
  end

  // Valid stays high across back-to-back requests; it drops only for a gap.
  task automatic send(request_t rq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= rq;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Registers change only with the block idle and nothing outstanding.
  task automatic set_regs(int rows, int cols, int ng, int cg, int ev);
    int vals [5];
    vals = '{rows, cols, ng, cg, ev};
    drain();
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= 16'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    rows_now = rows;
    cols_now = cols;
  endtask

  function automatic request_t mk(op_t op, int r, int c, int code, int draw);
    request_t rq;
    rq.operation = op;
    rq.row = 6'(r);
    rq.col = 6'(c);
    rq.cell_code = 2'(code);
    rq.random_value = 16'(draw);
    return rq;
  endfunction

  // Mostly moves and placements inside the grid; some wall and code
  // churn, out-of-range noise, and evaporation kept rare on large grids.
  function automatic request_t rand_req();
    request_t rq;
    int pick;
    rq = request_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      rq.operation = OP_MOVE;
    end else if (pick < 90) begin
      rq.operation = (pick < 70) ? OP_PLACE : OP_LOAD;
      if ($urandom_range(0, 9) != 0) begin
        rq.row = 6'($urandom_range(0, rows_now - 1));
        rq.col = 6'($urandom_range(0, cols_now - 1));
      end
      if (pick >= 70 && $urandom_range(0, 3) != 0) rq.cell_code = 2'd0;
    end else if (pick >= 97 || rows_now * cols_now <= 256) begin
      rq.operation = OP_EVAP;
    end else begin
      rq.operation = OP_MOVE;
    end
    return rq;
  endfunction

  initial begin
    int ph_rows [6] = '{3, 5, 12, 3, 12, 7};
    int ph_cols [6] = '{3, 8, 12, 12, 3, 6};
    int ph_ng   [6] = '{0, 65535, 14299, 30000, 65535, 5000};
    int ph_cg   [6] = '{0, 65535, 42598, 1, 0, 65535};
    int ph_ev   [6] = '{65535, 32768, 1000, 0, 65535, 200};

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    quiet = 1'b1;
    rows_now = 64;
    cols_now = 64;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the corner block first; every later grid but the full one below fits
    // inside it, so no move or evaporate touches an unwritten cell.
    for (int r = 0; r < FillSide; r++)
      for (int c = 0; c < FillSide; c++)
        send(mk(OP_LOAD, r, c, ($urandom_range(0, 9) == 0) ? CellWall : 0, 0));
    quiet = 1'b0;

    // Full 64x64 grid: one move from the far corner, inside a written block.
    for (int r = 61; r < 64; r++)
      for (int c = 61; c < 64; c++)
        send(mk(OP_LOAD, r, c, 0, 0));
    send(mk(OP_PLACE, 63, 63, 0, 0));
    send(mk(OP_MOVE, 0, 0, 0, 30000));

    // Directed: a 10x12 grid with defaults for the gains.
    set_regs(10, 12, 14299, 42598, 8000);
    send(mk(OP_LOAD, 63, 0, 0, 0));              // load out of range
    send(mk(OP_PLACE, 0, 63, 0, 0));             // place out of range
    send(mk(OP_LOAD, 2, 2, CellWall, 0));
    send(mk(OP_PLACE, 2, 2, 0, 0));              // place on wall
    send(mk(OP_LOAD, 0, 1, CellWall, 0));
    send(mk(OP_LOAD, 1, 0, CellWall, 0));
    send(mk(OP_LOAD, 1, 1, CellWall, 0));
    send(mk(OP_LOAD, 0, 0, CellVisited, 0));
    send(mk(OP_PLACE, 0, 0, 0, 0));
    send(mk(OP_MOVE, 0, 0, 0, 65535));           // boxed in by walls
    send(mk(OP_LOAD, 5, 5, CellRobot, 0));
    send(mk(OP_LOAD, 5, 6, 0, 0));
    send(mk(OP_PLACE, 5, 5, 0, 0));
    send(mk(OP_MOVE, 0, 0, 0, 0));               // draw at zero
    send(mk(OP_MOVE, 0, 0, 0, 65535));           // draw at the top
    send(mk(OP_MOVE, 63, 63, 3, 32768));
    send(mk(OP_EVAP, 0, 0, 0, 0));
    send(mk(OP_PLACE, 9, 11, 0, 0));             // far corner
    send(mk(OP_MOVE, 0, 0, 0, 12345));
    // shrink the grid under the robot, then try to move it
    send(mk(OP_PLACE, 9, 11, 0, 0));
    set_regs(5, 5, 14299, 42598, 8000);
    send(mk(OP_MOVE, 0, 0, 0, 40000));           // robot outside grid
    send(mk(OP_EVAP, 0, 0, 0, 0));

    for (int p = 0; p < 7; p++) begin
      if (p < 6) set_regs(ph_rows[p], ph_cols[p], ph_ng[p], ph_cg[p], ph_ev[p]);
      else set_regs($urandom_range(3, 12), $urandom_range(3, 12), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
      quiet = (p == 2);
      for (int i = 0; i < 32; i++) send(rand_req());
    end
    quiet = 1'b0;

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
